### hw/rtl/stt_pkg.sv
// package: types, codes and helpers of the scene text tokenizer
`default_nettype none
package stt_pkg;

  localparam int unsigned LenW = 9;
  localparam logic [LenW-1:0] MaxLenReset = 9'd255;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_WORD = 3'd1,
    MODE_STR  = 3'd2,
    MODE_ESC  = 3'd3,
    MODE_CMT  = 3'd4
  } scan_mode_t;

  localparam logic [1:0] EV_BYTE  = 2'd0;
  localparam logic [1:0] EV_END   = 2'd1;
  localparam logic [1:0] EV_ABORT = 2'd2;

  localparam logic [1:0] KIND_WORD = 2'd0;
  localparam logic [1:0] KIND_STR  = 2'd1;
  localparam logic [1:0] KIND_BRK  = 2'd2;
  localparam logic [1:0] KIND_CMT  = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NEWLINE  = 3'd1;
  localparam logic [2:0] ERR_ESCAPE   = 3'd2;
  localparam logic [2:0] ERR_TOO_LONG = 3'd3;
  localparam logic [2:0] ERR_UNTERM   = 3'd4;

  localparam logic REQ_END = 1'b1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_T  = 8'h74;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [1:0] token_kind;
    logic [7:0] token_byte;
    logic [2:0] error_code;
    logic       last_of_input;
  } tok_res_t;

  localparam tok_res_t RES_NONE = '{EV_BYTE, KIND_WORD, 8'd0, ERR_NONE, 1'b0};

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_bracket(input logic [7:0] c);
    return (c == CH_LBRK) || (c == CH_RBRK);
  endfunction

  // escape decode, bit 8 flags a valid escape
  function automatic logic [8:0] decode_escape(input logic [7:0] c);
    logic [8:0] d;
    case (c)
      CH_LC_B:   d = {1'b1, CH_BS};
      CH_LC_F:   d = {1'b1, CH_FF};
      CH_LC_N:   d = {1'b1, CH_LF};
      CH_LC_R:   d = {1'b1, CH_CR};
      CH_LC_T:   d = {1'b1, CH_TAB};
      CH_BSLASH: d = {1'b1, CH_BSLASH};
      CH_SQUOTE: d = {1'b1, CH_SQUOTE};
      CH_DQUOTE: d = {1'b1, CH_DQUOTE};
      default:   d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic tok_res_t mk_byte(input logic [1:0] kind, input logic [7:0] b);
    return '{EV_BYTE, kind, b, ERR_NONE, 1'b0};
  endfunction

  function automatic tok_res_t mk_end(input logic [1:0] kind);
    return '{EV_END, kind, 8'd0, ERR_NONE, 1'b0};
  endfunction

  function automatic tok_res_t mk_abort(input logic [1:0] kind, input logic [2:0] err);
    return '{EV_ABORT, kind, 8'd0, err, 1'b0};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/stt_if.sv
// interfaces: input, result and configuration channels of the tokenizer
`default_nettype none
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] text_byte;
  modport source (output valid, output req_type, output text_byte, input ready);
  modport sink   (input valid, input req_type, input text_byte, output ready);
endinterface

interface stt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [1:0] token_kind;
  logic [7:0] token_byte;
  logic [2:0] error_code;
  logic       last_of_input;
  modport source (output valid, output event_kind, output token_kind, output token_byte,
                  output error_code, output last_of_input, input ready);
  modport sink   (input valid, input event_kind, input token_kind, input token_byte,
                  input error_code, input last_of_input, output ready);
endinterface

interface stt_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] max_token_len;
  modport source (output valid, output max_token_len, input ready);
  modport sink   (input valid, input max_token_len, output ready);
endinterface
`default_nettype wire

### hw/rtl/scene_text_tokenizer_unit.sv
// top level: scene text tokenizer, byte stream in, token events out
// path: an input item is registered in the pending slot, then its results in the result register
// throughput: one item per cycle while each item gives at most one result and out_ch.ready
// is high; an item giving k results holds the result register for k output transfers
// reset: scanner idle, token length zero, max_token_len 255, no pending item
`default_nettype none
module scene_text_tokenizer_unit (
  input  wire        clk,
  input  wire        rst_n,
  stt_in_if.sink     in_ch,
  stt_out_if.source  out_ch,
  stt_cfg_if.sink    cfg_ch
);
  import stt_pkg::*;

  logic             pend_v_r;
  logic             pend_req_r;
  logic [7:0]       pend_byte_r;
  scan_mode_t       mode_r, mode_nxt;
  logic [LenW-1:0]  len_r, len_nxt;
  logic [LenW-1:0]  max_len_r;
  tok_res_t         res_r [3];
  tok_res_t         res_nxt [3];
  logic [1:0]       n_r, n_nxt;
  logic [1:0]       idx_r;

  logic out_take, last_take, buf_free, proc;

  // idle-byte scan results
  tok_res_t        ib_res0, ib_res1;
  logic [1:0]      ib_n;
  scan_mode_t      ib_mode;
  logic [LenW-1:0] ib_len;
  logic [1:0]      ib_kind;
  scan_mode_t      ib_tok_mode;

  logic [7:0] c;
  logic       put_ok;
  logic [8:0] esc;

  assign out_ch.valid = (idx_r != n_r);
  assign out_take     = out_ch.valid && out_ch.ready;
  assign last_take    = out_take && (idx_r == 2'(n_r - 2'd1));
  assign buf_free     = !out_ch.valid || last_take;
  assign proc         = pend_v_r && buf_free;
  assign in_ch.ready  = !pend_v_r || proc;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.event_kind    = res_r[idx_r].event_kind;
  assign out_ch.token_kind    = res_r[idx_r].token_kind;
  assign out_ch.token_byte    = res_r[idx_r].token_byte;
  assign out_ch.error_code    = res_r[idx_r].error_code;
  assign out_ch.last_of_input = res_r[idx_r].last_of_input;

  assign c      = pend_byte_r;
  assign put_ok = len_r < max_len_r;
  assign esc    = decode_escape(c);

  always_comb begin
    ib_res0 = RES_NONE;
    ib_res1 = RES_NONE;
    ib_n    = 2'd0;
    ib_mode = MODE_IDLE;
    ib_len  = '0;
    if (c == CH_DQUOTE) begin
      ib_kind     = KIND_STR;
      ib_tok_mode = MODE_STR;
    end else if (c == CH_HASH) begin
      ib_kind     = KIND_CMT;
      ib_tok_mode = MODE_CMT;
    end else if (is_bracket(c)) begin
      ib_kind     = KIND_BRK;
      ib_tok_mode = MODE_IDLE;
    end else begin
      ib_kind     = KIND_WORD;
      ib_tok_mode = MODE_WORD;
    end
    if (!is_space(c)) begin
      if (max_len_r == '0) begin
        ib_res0 = mk_abort(ib_kind, ERR_TOO_LONG);
        ib_n    = 2'd1;
      end else if (is_bracket(c)) begin
        ib_res0 = mk_byte(KIND_BRK, c);
        ib_res1 = mk_end(KIND_BRK);
        ib_n    = 2'd2;
      end else begin
        ib_res0 = mk_byte(ib_kind, c);
        ib_n    = 2'd1;
        ib_mode = ib_tok_mode;
        ib_len  = LenW'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_nxt[i] = RES_NONE;
    end
    n_nxt    = 2'd0;
    mode_nxt = mode_r;
    len_nxt  = len_r;
    if (pend_req_r == REQ_END) begin
      mode_nxt = MODE_IDLE;
      len_nxt  = '0;
      case (mode_r)
        MODE_WORD: begin
          res_nxt[0] = mk_end(KIND_WORD);
          n_nxt      = 2'd1;
        end
        MODE_CMT: begin
          res_nxt[0] = mk_end(KIND_CMT);
          n_nxt      = 2'd1;
        end
        MODE_STR, MODE_ESC: begin
          res_nxt[0] = mk_abort(KIND_STR, ERR_UNTERM);
          n_nxt      = 2'd1;
        end
        default: n_nxt = 2'd0;
      endcase
    end else begin
      case (mode_r)
        MODE_WORD: begin
          if (is_space(c) || c == CH_DQUOTE || is_bracket(c)) begin
            res_nxt[0] = mk_end(KIND_WORD);
            res_nxt[1] = ib_res0;
            res_nxt[2] = ib_res1;
            n_nxt      = 2'(2'd1 + ib_n);
            mode_nxt   = ib_mode;
            len_nxt    = ib_len;
          end else if (put_ok) begin
            res_nxt[0] = mk_byte(KIND_WORD, c);
            n_nxt      = 2'd1;
            len_nxt    = LenW'(len_r + 1'b1);
          end else begin
            res_nxt[0] = mk_abort(KIND_WORD, ERR_TOO_LONG);
            n_nxt      = 2'd1;
            mode_nxt   = MODE_IDLE;
            len_nxt    = '0;
          end
        end
        MODE_STR: begin
          if (c == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else if (c == CH_LF) begin
            res_nxt[0] = mk_abort(KIND_STR, ERR_NEWLINE);
            n_nxt      = 2'd1;
            mode_nxt   = MODE_IDLE;
            len_nxt    = '0;
          end else if (!put_ok) begin
            res_nxt[0] = mk_abort(KIND_STR, ERR_TOO_LONG);
            n_nxt      = 2'd1;
            mode_nxt   = MODE_IDLE;
            len_nxt    = '0;
          end else if (c == CH_DQUOTE) begin
            res_nxt[0] = mk_byte(KIND_STR, c);
            res_nxt[1] = mk_end(KIND_STR);
            n_nxt      = 2'd2;
            mode_nxt   = MODE_IDLE;
            len_nxt    = '0;
          end else begin
            res_nxt[0] = mk_byte(KIND_STR, c);
            n_nxt      = 2'd1;
            len_nxt    = LenW'(len_r + 1'b1);
          end
        end
        MODE_ESC: begin
          n_nxt = 2'd1;
          if (c == CH_LF) begin
            res_nxt[0] = mk_abort(KIND_STR, ERR_NEWLINE);
            mode_nxt   = MODE_IDLE;
            len_nxt    = '0;
          end else if (!esc[8]) begin
            res_nxt[0] = mk_abort(KIND_STR, ERR_ESCAPE);
            mode_nxt   = MODE_IDLE;
            len_nxt    = '0;
          end else if (!put_ok) begin
            res_nxt[0] = mk_abort(KIND_STR, ERR_TOO_LONG);
            mode_nxt   = MODE_IDLE;
            len_nxt    = '0;
          end else begin
            res_nxt[0] = mk_byte(KIND_STR, esc[7:0]);
            mode_nxt   = MODE_STR;
            len_nxt    = LenW'(len_r + 1'b1);
          end
        end
        MODE_CMT: begin
          n_nxt = 2'd1;
          if (c == CH_LF || c == CH_CR) begin
            res_nxt[0] = mk_end(KIND_CMT);
            mode_nxt   = MODE_IDLE;
            len_nxt    = '0;
          end else if (!put_ok) begin
            res_nxt[0] = mk_abort(KIND_CMT, ERR_TOO_LONG);
            mode_nxt   = MODE_IDLE;
            len_nxt    = '0;
          end else begin
            res_nxt[0] = mk_byte(KIND_CMT, c);
            len_nxt    = LenW'(len_r + 1'b1);
          end
        end
        default: begin
          res_nxt[0] = ib_res0;
          res_nxt[1] = ib_res1;
          n_nxt      = ib_n;
          mode_nxt   = ib_mode;
          len_nxt    = ib_len;
        end
      endcase
    end
    for (int i = 0; i < 3; i++) begin
      res_nxt[i].last_of_input = (2'(i) == 2'(n_nxt - 2'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r  <= 1'b0;
      mode_r    <= MODE_IDLE;
      len_r     <= '0;
      max_len_r <= MaxLenReset;
      n_r       <= 2'd0;
      idx_r     <= 2'd0;
    end else begin
      if (in_ch.ready) begin
        pend_v_r <= in_ch.valid;
      end
      if (cfg_ch.valid) begin
        max_len_r <= cfg_ch.max_token_len;
      end
      if (proc) begin
        mode_r <= mode_nxt;
        len_r  <= len_nxt;
        n_r    <= n_nxt;
        idx_r  <= 2'd0;
      end else if (last_take) begin
        n_r   <= 2'd0;
        idx_r <= 2'd0;
      end else if (out_take) begin
        idx_r <= 2'(idx_r + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      pend_req_r  <= in_ch.req_type;
      pend_byte_r <= in_ch.text_byte;
    end
    if (proc) begin
      for (int i = 0; i < 3; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end
  end

  a_idle_len: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (len_r == '0))
    else $error("token length not cleared while scanner idle");

  a_more_results: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !out_ch.last_of_input) |=> out_ch.valid)
    else $error("results of an item dropped before its last one");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last_of_input == (idx_r == 2'(n_r - 2'd1))))
    else $error("last flag out of step with result position");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_v_r && !buf_free) |-> !in_ch.ready)
    else $error("input taken while pending item blocked");

endmodule
`default_nettype wire
